>>> rtl/dtc_pkg.sv
`default_nettype none

package dtc_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic [7:0]  dy;
    logic [7:0]  dx;
    logic [15:0] y;
    logic [15:0] x;
  } key_t;

  localparam int unsigned KEY_W     = $bits(key_t);
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned IDX_OUT_W  = 8;
  localparam int unsigned UNIQ_OUT_W = 9;
  localparam int unsigned CNT_OUT_W  = 32;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic                 was_new;
    logic                 full;
    logic [CNT_OUT_W-1:0] count;
    key_t                 key;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/dtc_ram.sv
`default_nettype none

module dtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/distinct_tuple_counter_top.sv
// channel | dir | tdata fields, lowest bit first
// in_     | in  | func[1:0] x[17:2] y[33:18] dx[41:34] dy[49:42] read_index[57:50]
// out_    | out | entry_index[7:0] was_new[8] table_full[9] entry_count[41:10]
//         |     | unique_total[50:42] sample_count[82:51] entry_x[98:83]
//         |     | entry_y[114:99] entry_dx[122:115] entry_dy[130:123]
// Insert: the tuple store is scanned one entry per cycle
// through the single read port of the memory, and a match ends the scan early.
// Read: the memory is read only when the index is within the stored entries. Clear and no-op skip the memory.
// One transfer is worked on at a time; in_tready is high only when the sequencer idles.
// A finished result waits in the output register; the next transfer may be taken then.
// Reset empties the table at once; stale memory words are never read.
`default_nettype none

module distinct_tuple_counter_top #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // func, x, y, dx, dy, read_index
  input  wire logic [dtc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // entry_index, was_new, table_full, entry_count, unique_total, sample_count,
  // entry_x, entry_y, entry_dx, entry_dy
  output logic      [dtc_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int unsigned IDXW = $clog2(ENTRIES);
  localparam int unsigned DW   = IDXW + 1;
  localparam int unsigned MW   = dtc_pkg::KEY_W + COUNT_WIDTH;
  localparam int unsigned XW   = COUNT_WIDTH + dtc_pkg::CNT_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RDWAIT,
    ST_OUT
  } state_t;

  state_t                   state_r;
  logic [DW-1:0]            distinct_r;
  logic [COUNT_WIDTH-1:0]   sample_r;
  logic [DW-1:0]            scan_idx_r;
  logic [IDXW-1:0]          cmp_idx_r;
  logic                     cmp_valid_r;
  logic [IDXW-1:0]          wr_idx_r;
  logic [COUNT_WIDTH-1:0]   cnt_r;
  logic                     new_r;
  dtc_pkg::key_t            key_r;
  dtc_pkg::result_t         res_r;
  logic                     out_valid_r;
  logic [dtc_pkg::OUT_DATA_W-1:0] out_tdata_r;

  dtc_pkg::func_t           in_func;
  dtc_pkg::key_t            in_key;
  logic [7:0]               in_ridx;
  logic [IDXW+7:0]          ridx_ext;
  logic                     rd_in_range;
  logic                     in_xfer;
  dtc_pkg::result_t         res_init;

  logic                     ram_we;
  logic [IDXW-1:0]          ram_waddr;
  logic [MW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [IDXW-1:0]          ram_raddr;
  logic [MW-1:0]            ram_rdata;
  dtc_pkg::key_t            rd_key;
  logic [COUNT_WIDTH-1:0]   rd_cnt;
  logic                     hit;
  logic                     scan_more;

  logic [XW-1:0]            rd_cnt_x;
  logic [XW-1:0]            cnt_x;
  logic [XW-1:0]            sample_x;
  logic [IDXW+7:0]          wr_idx_x;
  logic [IDXW+8:0]          distinct_x;
  logic [DW-1:0]            distinct_post;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign in_func   = dtc_pkg::func_t'(in_tdata[1:0]);
  assign in_key    = dtc_pkg::key_t'(in_tdata[49:2]);
  assign in_ridx   = in_tdata[57:50];
  assign ridx_ext  = (IDXW + 8)'(in_ridx);
  assign rd_in_range = (IDXW + 9)'(in_ridx) < (IDXW + 9)'(distinct_r);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign rd_key    = dtc_pkg::key_t'(ram_rdata[dtc_pkg::KEY_W-1:0]);
  assign rd_cnt    = ram_rdata[MW-1:dtc_pkg::KEY_W];
  assign hit       = cmp_valid_r && (rd_key == key_r);
  assign scan_more = scan_idx_r < distinct_r;

  always_comb begin
    rd_cnt_x      = XW'(rd_cnt);
    cnt_x         = XW'(sat_inc(cnt_r));
    sample_x      = XW'(sample_r);
    wr_idx_x      = (IDXW + 8)'(wr_idx_r);
    distinct_x    = (IDXW + 9)'(distinct_r);
    distinct_post = new_r ? distinct_r + DW'(1) : distinct_r;
    res_init      = '0;
    res_init.idx  = (in_func == dtc_pkg::FUNC_READ) ? in_ridx : '0;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx_r;
    ram_wdata = {cnt_x[COUNT_WIDTH-1:0], key_r};
    ram_re    = 1'b0;
    ram_raddr = scan_idx_r[IDXW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = ridx_ext[IDXW-1:0];
        ram_re    = in_xfer && (in_func == dtc_pkg::FUNC_READ) && rd_in_range;
      end
      ST_SCAN: begin
        ram_re = !hit && scan_more;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  dtc_ram #(
    .WIDTH (MW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      distinct_r  <= '0;
      sample_r    <= '0;
      cmp_valid_r <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            res_r <= res_init;
            unique case (in_func)
              dtc_pkg::FUNC_INSERT: begin
                key_r       <= in_key;
                scan_idx_r  <= '0;
                cmp_valid_r <= 1'b0;
                state_r     <= ST_SCAN;
              end
              dtc_pkg::FUNC_READ: begin
                state_r <= rd_in_range ? ST_RDWAIT : ST_OUT;
              end
              dtc_pkg::FUNC_CLEAR: begin
                distinct_r <= '0;
                sample_r   <= '0;
                state_r    <= ST_OUT;
              end
              dtc_pkg::FUNC_NOP: begin
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          priority if (hit) begin
            wr_idx_r <= cmp_idx_r;
            cnt_r    <= rd_cnt;
            new_r    <= 1'b0;
            state_r  <= ST_WRITE;
          end else if (scan_more) begin
            cmp_idx_r   <= scan_idx_r[IDXW-1:0];
            cmp_valid_r <= 1'b1;
            scan_idx_r  <= scan_idx_r + DW'(1);
          end else if (distinct_r < DW'(ENTRIES)) begin
            wr_idx_r <= distinct_r[IDXW-1:0];
            cnt_r    <= '0;
            new_r    <= 1'b1;
            state_r  <= ST_WRITE;
          end else begin
            res_r.full <= 1'b1;
            state_r    <= ST_OUT;
          end
        end
        ST_WRITE: begin
          cnt_r         <= sat_inc(cnt_r);
          sample_r      <= sat_inc(sample_r);
          distinct_r    <= distinct_post;
          res_r.idx     <= wr_idx_x[7:0];
          res_r.was_new <= new_r;
          res_r.count   <= cnt_x[dtc_pkg::CNT_OUT_W-1:0];
          res_r.key     <= key_r;
          state_r       <= ST_OUT;
        end
        ST_RDWAIT: begin
          res_r.count <= rd_cnt_x[dtc_pkg::CNT_OUT_W-1:0];
          res_r.key   <= rd_key;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tdata_r <= {5'd0, res_r.key.dy, res_r.key.dx, res_r.key.y, res_r.key.x,
                            sample_x[dtc_pkg::CNT_OUT_W-1:0],
                            distinct_x[dtc_pkg::UNIQ_OUT_W-1:0],
                            res_r.count, res_r.full, res_r.was_new, res_r.idx};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // ram write data carries the incremented count in the write cycle
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer took a transfer and stayed idle");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) && new_r |-> distinct_r < DW'(ENTRIES))
    else $error("append past the end of the table");

  a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && cmp_valid_r |-> DW'(cmp_idx_r) < distinct_r)
    else $error("compare on an entry beyond the stored count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> scan_idx_r <= distinct_r)
    else $error("scan index ran past the stored count");

  a_no_write_outside: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WRITE) && !ram_re)
    else $error("memory written outside the write step");

endmodule

`default_nettype wire
